// ===== rtl/arm_pkg.sv =====
// Shared types and constants for the assignment reduce and match block.
`default_nettype none
package arm_pkg;
	localparam int CW = 17;
	localparam logic [CW-1:0] INF = 17'h10000;

	// Datapath commands issued by the controller.
	typedef struct packed {
		logic load_wr;
		logic wr_en;
		logic clr_min;
		logic upd_min;
		logic clr_match;
		logic do_match;
	} arm_cmd_t;
endpackage
`default_nettype wire

// ===== rtl/arm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module arm_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read on the clock.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/arm_datapath.sv =====
// Datapath: cost storage, minimum tracking, subtraction and greedy match state.
`default_nettype none
module arm_datapath #(
	parameter int MAX_N = 16,
	localparam int IW = $clog2(MAX_N) > 0 ? $clog2(MAX_N) : 1,
	localparam int AW = $clog2(MAX_N*MAX_N) > 0 ? $clog2(MAX_N*MAX_N) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire arm_pkg::arm_cmd_t   cmd,
	input  wire logic [15:0]         cost,
	input  wire logic [AW-1:0]       waddr,
	input  wire logic [AW-1:0]       raddr,
	input  wire logic [IW-1:0]       cur_row,
	input  wire logic [IW-1:0]       cur_col,
	input  wire logic                col_pass,
	input  wire logic [IW-1:0]       out_row,
	output logic signed [4:0]        col_of_row,
	output logic [3:0]               cf_row,
	output logic [3:0]               cf_col,
	output logic                     cf_seen
);
	import arm_pkg::*;

	logic [CW-1:0] rdata, wdata, min_q, subv;
	logic          held;
	logic [IW-1:0] holder;
	logic signed [5:0] cor_q [MAX_N];
	logic [MAX_N-1:0]  taken_q;
	logic [IW-1:0]     owner_q [MAX_N];
	logic [3:0] cfr_q, cfc_q;
	logic       cfs_q;

	arm_ram #(.WIDTH(CW), .DEPTH(MAX_N*MAX_N)) u_ram (
		.clk(clk), .we(cmd.load_wr | cmd.wr_en), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Subtract the running minimum unless skipped.
	always_comb begin
		subv = rdata;
		if (rdata != INF && min_q != INF && !(col_pass && min_q == '0))
			subv = rdata - min_q;
		wdata = cmd.load_wr ? ((cost == 16'd0) ? INF : {1'b0, cost}) : subv;
	end

	// Track the minimum over a row or column.
	always_ff @(posedge clk) begin
		if (cmd.clr_min) min_q <= INF;
		else if (cmd.upd_min && rdata < min_q) min_q <= rdata;
	end

	assign held = taken_q[cur_col];
	assign holder = owner_q[cur_col];

	// Greedy match: claim free zero columns, record conflicts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			cfr_q <= '0; cfc_q <= '0; cfs_q <= 1'b0;
			for (int i = 0; i < MAX_N; i++) cor_q[i] <= -6'sd1;
		end else if (cmd.clr_match) begin
			taken_q <= '0;
			cfr_q <= '0; cfc_q <= '0; cfs_q <= 1'b0;
			for (int i = 0; i < MAX_N; i++) cor_q[i] <= -6'sd1;
		end else if (cmd.do_match && rdata == '0) begin
			if (held) begin
				cfr_q <= 4'(holder); cfc_q <= 4'(cur_col); cfs_q <= 1'b1;
			end else begin
				if (cor_q[cur_row] >= 0) taken_q[cor_q[cur_row][IW-1:0]] <= 1'b0;
				taken_q[cur_col] <= 1'b1;
				cor_q[cur_row] <= 6'(cur_col);
			end
		end
	end

	// Hold owner for each column.
	always_ff @(posedge clk) begin
		if (cmd.do_match && rdata == '0 && !held) owner_q[cur_col] <= cur_row;
	end

	assign col_of_row = 5'(cor_q[out_row]);
	assign cf_row = cfr_q;
	assign cf_col = cfc_q;
	assign cf_seen = cfs_q;
endmodule
`default_nettype wire

// ===== rtl/arm_ctrl.sv =====
// Controller: load sequencing, reduction passes, match pass and result output.
`default_nettype none
module arm_ctrl #(
	parameter int MAX_N = 16,
	localparam int IW = $clog2(MAX_N) > 0 ? $clog2(MAX_N) : 1,
	localparam int AW = $clog2(MAX_N*MAX_N) > 0 ? $clog2(MAX_N*MAX_N) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [4:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output arm_pkg::arm_cmd_t      cmd,
	output logic [AW-1:0]          waddr,
	output logic [AW-1:0]          raddr,
	output logic [IW-1:0]          cur_row,
	output logic [IW-1:0]          cur_col,
	output logic                   col_pass,
	output logic [IW-1:0]          out_row,
	output logic                   last
);
	import arm_pkg::*;

	localparam logic [2:0] S_LOAD = 3'd0, S_MIN = 3'd1, S_SUB = 3'd2,
		S_MATCH = 3'd3, S_OUT = 3'd4;
	localparam logic [1:0] P_READ = 2'd0, P_WAIT = 2'd1, P_DO = 2'd2;

	logic [2:0] state_q;
	logic [1:0] ph_q;
	logic [4:0] size_q;
	logic [6:0] n;
	logic [AW:0] cnt_q;
	logic [IW:0] a_q, b_q;
	logic cp_q;
	logic [IW:0] r, c;
	logic a_last, b_last;

	// Clamp the size to the supported range.
	always_comb begin
		if (size_q == '0) n = 7'd1;
		else if (7'(size_q) > 7'(MAX_N)) n = 7'(MAX_N);
		else n = 7'(size_q);
	end

	// a is the outer index, b the inner; swap for the column pass.
	assign r = cp_q ? b_q : a_q;
	assign c = cp_q ? a_q : b_q;
	assign a_last = (7'(a_q) == n - 7'd1);
	assign b_last = (7'(b_q) == n - 7'd1);
	assign cur_row = r[IW-1:0];
	assign cur_col = c[IW-1:0];
	assign col_pass = cp_q;
	assign raddr = AW'(14'(r) * 14'(n) + 14'(c));
	assign waddr = (state_q == S_LOAD) ? cnt_q[AW-1:0] : raddr;
	assign in_stall = (state_q != S_LOAD);
	assign out_valid = (state_q == S_OUT);
	assign out_row = a_q[IW-1:0];
	assign last = a_last;

	// Decode commands from state and phase.
	always_comb begin
		cmd = '0;
		cmd.load_wr = (state_q == S_LOAD) && in_valid;
		cmd.upd_min = (state_q == S_MIN) && ph_q == P_DO;
		cmd.wr_en = (state_q == S_SUB) && ph_q == P_DO;
		cmd.do_match = (state_q == S_MATCH) && ph_q == P_DO;
		cmd.clr_min = (state_q == S_LOAD) || (state_q == S_SUB && ph_q == P_DO && b_last);
		cmd.clr_match = (state_q == S_LOAD);
	end

	// Advance the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD; ph_q <= P_READ; size_q <= 5'd16;
			cnt_q <= '0; a_q <= '0; b_q <= '0; cp_q <= 1'b0;
		end else if (cfg_valid) begin
			size_q <= cfg_data; cnt_q <= '0;
		end else begin
			case (state_q)
				S_LOAD: if (in_valid) begin
					if (14'(cnt_q) + 14'd1 == 14'(n) * 14'(n)) begin
						cnt_q <= '0; state_q <= S_MIN; ph_q <= P_READ;
						a_q <= '0; b_q <= '0; cp_q <= 1'b0;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_MIN, S_SUB, S_MATCH: begin
					case (ph_q)
						P_READ: ph_q <= P_WAIT;
						P_WAIT: ph_q <= P_DO;
						default: begin
							ph_q <= P_READ;
							if (!b_last) b_q <= b_q + 1'b1;
							else begin
								b_q <= '0;
								if (state_q == S_MIN) state_q <= S_SUB;
								else if (state_q == S_MATCH) begin
									if (a_last) begin a_q <= '0; state_q <= S_OUT; end
									else a_q <= a_q + 1'b1;
								end else if (!a_last) begin
									a_q <= a_q + 1'b1; state_q <= S_MIN;
								end else begin
									a_q <= '0;
									if (!cp_q) begin cp_q <= 1'b1; state_q <= S_MIN; end
									else begin cp_q <= 1'b0; state_q <= S_MATCH; end
								end
							end
						end
					endcase
				end
				S_OUT: if (!out_stall) begin
					if (a_last) begin a_q <= '0; state_q <= S_LOAD; end
					else a_q <= a_q + 1'b1;
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Results are only offered after a full load.
	a_out_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("output while loading");
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_wr && cmd.wr_en)) else $error("two writes");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && !cfg_valid) |=> (out_valid && $stable(out_row)))
		else $error("result dropped");
endmodule
`default_nettype wire

// ===== rtl/assignment_reduce_and_greedy_match.sv =====
// Top level of the assignment reduce and greedy match block.
// Loads N*N costs at one per cycle (in_stall low while loading), then works
// on the stored matrix through one RAM read port: row minimum, row subtract,
// column minimum, column subtract and a greedy match pass, each entry stepping
// through a read, a read-latency and an update phase. N results follow at
// one per cycle while out_stall is low; input is stalled until the last is taken.
`default_nettype none
module assignment_reduce_and_greedy_match #(
	parameter int MAX_N = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [4:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [15:0]       cost,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [3:0]             row_index,
	output logic signed [4:0]      assigned_column,
	output logic [3:0]             conflict_row,
	output logic [3:0]             conflict_column,
	output logic                   conflict_seen,
	output logic                   last_row
);
	import arm_pkg::*;
	localparam int IW = $clog2(MAX_N) > 0 ? $clog2(MAX_N) : 1;
	localparam int AW = $clog2(MAX_N*MAX_N) > 0 ? $clog2(MAX_N*MAX_N) : 1;

	arm_cmd_t cmd;
	logic [AW-1:0] waddr, raddr;
	logic [IW-1:0] cur_row, cur_col, out_row;
	logic col_pass, stall_int;

	assign cfg_ready = 1'b1;
	assign in_stall = stall_int | cfg_valid;
	assign row_index = 4'(out_row);

	arm_ctrl #(.MAX_N(MAX_N)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.in_valid(in_valid && !cfg_valid), .in_stall(stall_int), .out_valid(out_valid),
		.out_stall(out_stall), .cmd(cmd), .waddr(waddr), .raddr(raddr),
		.cur_row(cur_row), .cur_col(cur_col), .col_pass(col_pass),
		.out_row(out_row), .last(last_row)
	);

	arm_datapath #(.MAX_N(MAX_N)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cost(cost), .waddr(waddr),
		.raddr(raddr), .cur_row(cur_row), .cur_col(cur_col), .col_pass(col_pass),
		.out_row(out_row), .col_of_row(assigned_column), .cf_row(conflict_row),
		.cf_col(conflict_column), .cf_seen(conflict_seen)
	);
endmodule
`default_nettype wire

// ===== bench/assignment_reduce_and_greedy_match_tb.sv =====
// Self-checking testbench for the assignment reduce and greedy match block.
`default_nettype none
module assignment_reduce_and_greedy_match_tb;
	import arm_pkg::*;

	localparam int MAXN = 16;
	localparam int INF_COST = 32'h10000;

	typedef struct packed {
		logic [3:0]        row;
		logic signed [4:0] col;
		logic [3:0]        crow;
		logic [3:0]        ccol;
		logic              seen;
		logic              last;
	} match_res_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [4:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [15:0] cost;
	logic out_valid;
	logic out_stall;
	logic [3:0] row_index;
	logic signed [4:0] assigned_column;
	logic [3:0] conflict_row;
	logic [3:0] conflict_column;
	logic conflict_seen;
	logic last_row;

	// Predictor state
	logic [4:0] size_reg;
	int cost_mem [MAXN*MAXN];
	int load_count;
	match_res_t pending_rows[$];

	int mismatches;
	int failures;
	bit idle_on;
	int hold_cycles;
	int stall_burst;

	assignment_reduce_and_greedy_match #(.MAX_N(MAXN)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .cost(cost),
		.out_valid(out_valid), .out_stall(out_stall),
		.row_index(row_index), .assigned_column(assigned_column),
		.conflict_row(conflict_row), .conflict_column(conflict_column),
		.conflict_seen(conflict_seen), .last_row(last_row)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int active_n();
		if (size_reg == 0)
			return 1;
		if (size_reg > MAXN)
			return MAXN;
		return int'(size_reg);
	endfunction

	// Reduce rows then columns, match greedily, queue one row result each
	task automatic solve_matrix(input int n);
		int w [MAXN*MAXN];
		int col_of [MAXN];
		int m;
		int crow;
		int ccol;
		bit seen;
		bit held;
		match_res_t res;
		for (int i = 0; i < n*n; i++)
			w[i] = cost_mem[i];
		for (int r = 0; r < n; r++) begin
			m = INF_COST;
			for (int c = 0; c < n; c++)
				if (w[r*n+c] < m) m = w[r*n+c];
			if (m != INF_COST)
				for (int c = 0; c < n; c++)
					if (w[r*n+c] != INF_COST) w[r*n+c] -= m;
		end
		for (int c = 0; c < n; c++) begin
			m = INF_COST;
			for (int r = 0; r < n; r++)
				if (w[r*n+c] < m) m = w[r*n+c];
			if (m != 0 && m != INF_COST)
				for (int r = 0; r < n; r++)
					if (w[r*n+c] != INF_COST) w[r*n+c] -= m;
		end
		for (int i = 0; i < MAXN; i++)
			col_of[i] = -1;
		crow = 0;
		ccol = 0;
		seen = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				if (w[i*n+j] == 0) begin
					held = 0;
					for (int k = 0; k < n; k++)
						if (!held && col_of[k] == j) begin
							crow = k;
							ccol = j;
							seen = 1;
							held = 1;
						end
					if (!held) col_of[i] = j;
				end
			end
		for (int r = 0; r < n; r++) begin
			res.row = r[3:0];
			res.col = col_of[r][4:0];
			res.crow = crow[3:0];
			res.ccol = ccol[3:0];
			res.seen = seen;
			res.last = (r == n - 1);
			pending_rows.push_back(res);
		end
	endtask

	task automatic absorb_cost(input logic [15:0] v);
		int n;
		n = active_n();
		if (load_count >= n*n) load_count = 0;
		cost_mem[load_count] = (v == 0) ? INF_COST : int'(v);
		load_count++;
		if (load_count == n*n) begin
			load_count = 0;
			solve_matrix(n);
		end
	endtask

	// Send one cost request; called at a falling edge, returns at one
	task automatic send_cost(input logic [15:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid = 1'b1;
		cost = v;
		do @(posedge clk); while (in_stall);
		absorb_cost(v);
		@(negedge clk);
	endtask

	task automatic write_size(input logic [4:0] v);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		size_reg = v;
		load_count = 0;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold until every expected row is out, then let the block settle
	task automatic drain();
		in_valid = 1'b0;
		while (pending_rows.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_cost();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return 16'd0;
		if (pick < 7) return 16'($urandom_range(1, 4));
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic send_matrix(input int n);
		for (int i = 0; i < n*n; i++)
			send_cost(rand_cost());
	endtask

	// Default size after reset is 16: a short load yields no result
	task automatic test_reset_size();
		send_cost(16'hFFFF);
		send_cost(16'h0000);
		for (int i = 2; i < 20; i++)
			send_cost(rand_cost());
		drain();
	endtask

	// Sizes at the edges: zero acts as one, one itself, oversize acts as 16
	task automatic test_size_extremes();
		write_size(5'd0);
		send_cost(16'd0);
		send_cost(16'hFFFF);
		send_cost(16'd1);
		drain();
		write_size(5'd1);
		send_cost(16'h8000);
		drain();
		write_size(5'd31);
		repeat (20) send_cost(rand_cost());
		drain();
	endtask

	// Infinite row, columns left alone, conflicting zeros
	task automatic test_special_cases();
		logic [15:0] m3 [9] = '{0, 0, 0, 5, 5, 7, 2, 2, 9};
		logic [15:0] m2 [4] = '{3, 3, 3, 3};
		write_size(5'd3);
		foreach (m3[i]) send_cost(m3[i]);
		drain();
		write_size(5'd2);
		foreach (m2[i]) send_cost(m2[i]);
		drain();
	endtask

	// Rewriting the size mid-load discards the partial matrix
	task automatic test_load_restart();
		write_size(5'd4);
		repeat (5) send_cost(rand_cost());
		drain();
		write_size(5'd2);
		send_matrix(2);
		drain();
	endtask

	// Stall the output for a long stretch while costs keep coming
	task automatic test_backpressure();
		write_size(5'd3);
		hold_cycles = 400;
		repeat (2) send_matrix(3);
		drain();
	endtask

	task automatic test_random();
		int sent;
		int n;
		sent = 0;
		while (sent < 30) begin
			n = $urandom_range(1, 5);
			write_size(n[4:0]);
			repeat ($urandom_range(1, 3)) begin
				send_matrix(n);
				sent += n*n;
			end
			drain();
		end
	endtask

	task automatic test_no_idle();
		idle_on = 0;
		write_size(5'd3);
		repeat (2) send_matrix(3);
		drain();
	endtask

	// Output stall: long hold first, then random bursts
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (stall_burst > 0) begin
			out_stall <= 1'b1;
			stall_burst <= stall_burst - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_burst <= $urandom_range(0, 10);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each accepted row result with the oldest expectation
	always @(posedge clk) begin
		match_res_t want;
		match_res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{row_index, assigned_column, conflict_row, conflict_column,
				conflict_seen, last_row};
			if (pending_rows.size() == 0) begin
				failures++;
				if (failures + mismatches <= 10)
					$display("unexpected result row=%0d col=%0d", row_index,
						assigned_column);
			end else begin
				want = pending_rows.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp row=%0d col=%0d crow=%0d ccol=%0d",
							" seen=%0d last=%0d got row=%0d col=%0d crow=%0d",
							" ccol=%0d seen=%0d last=%0d"},
							want.row, want.col, want.crow, want.ccol, want.seen,
							want.last, got.row, got.col, got.crow, got.ccol,
							got.seen, got.last);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		cost = '0;
		out_stall = 1'b0;
		size_reg = 5'd16;
		load_count = 0;
		mismatches = 0;
		failures = 0;
		hold_cycles = 0;
		stall_burst = 0;
		idle_on = 1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_size();
		test_size_extremes();
		test_special_cases();
		test_load_restart();
		test_backpressure();
		test_random();
		test_no_idle();
		if (mismatches == 0 && failures == 0 && pending_rows.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
